// File: src/factorial_prime_exponents_unit_macros.svh
// ----------------------------------------------------------------------------
// factorial_prime_exponents_unit_macros
// Assertion macros shared by the factorial prime exponent unit.
// ----------------------------------------------------------------------------
`ifndef FACTORIAL_PRIME_EXPONENTS_UNIT_MACROS_SVH
`define FACTORIAL_PRIME_EXPONENTS_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define FPE_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define FPE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/fpe_pkg.sv
// ----------------------------------------------------------------------------
// fpe_pkg
// Types, constants and prime tables for the factorial prime exponent unit.
// ----------------------------------------------------------------------------
package fpe_pkg;

    localparam int C_N_W         = 7;
    localparam int C_N_SPAN      = 2 ** C_N_W;
    localparam int C_MAX_N       = 100;
    localparam int C_MAX_RESULTS = 25;

    localparam logic [C_N_W-1:0] C_FIRST_PRIME = C_N_W'(2);

    typedef logic [C_N_W-1:0] t_ptab [C_N_SPAN];

    typedef struct packed {
        logic load;
        logic next;
        logic start_prime;
        logic sub;
        logic restage;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic v_gt_n;
        logic v_prime;
        logic r_ge_p;
        logic c_ge_p;
        logic p_is_last;
    } t_dp_stat;

    function automatic logic [C_N_SPAN-1:0] f_prime_mask();
        logic [C_N_SPAN-1:0] m;
        int i;
        int j;
        m    = '1;
        m[0] = 1'b0;
        m[1] = 1'b0;
        for (i = 2; i * i < C_N_SPAN; i++) begin
            if (m[i]) begin
                for (j = i * i; j < C_N_SPAN; j += i) begin
                    m[j] = 1'b0;
                end
            end
        end
        return m;
    endfunction

    localparam logic [C_N_SPAN-1:0] C_PRIME_MASK = f_prime_mask();

    // largest prime not above the index, among the first C_MAX_RESULTS primes
    function automatic t_ptab f_last_prime_tab();
        t_ptab t;
        logic [C_N_W-1:0] last;
        int cnt;
        int v;
        last = '0;
        cnt  = 0;
        for (v = 0; v < C_N_SPAN; v++) begin
            if (C_PRIME_MASK[v] && cnt < C_MAX_RESULTS) begin
                last = C_N_W'(v);
                cnt++;
            end
            t[v] = last;
        end
        return t;
    endfunction

    localparam t_ptab C_LAST_PRIME = f_last_prime_tab();

endpackage

// File: src/fpe_ctrl.sv
// ----------------------------------------------------------------------------
// fpe_ctrl
// Sequencer: scans candidates, runs the subtract loop per prime, emits words.
// ----------------------------------------------------------------------------
module fpe_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  fpe_pkg::t_dp_stat i_stat,
    output fpe_pkg::t_dp_cmd  o_cmd
);
    import fpe_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DIV  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.v_gt_n) begin
                    n_state = S_IDLE;
                end else if (i_stat.v_prime) begin
                    o_cmd.start_prime = 1'b1;
                    n_state           = S_DIV;
                end else begin
                    o_cmd.next = 1'b1;
                end
            end
            S_DIV: begin
                if (i_stat.r_ge_p) begin
                    o_cmd.sub = 1'b1;
                end else if (i_stat.c_ge_p) begin
                    o_cmd.restage = 1'b1;
                end else begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_stat.p_is_last ? S_IDLE : S_SCAN;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

// File: src/fpe_datapath.sv
// ----------------------------------------------------------------------------
// fpe_datapath
// Candidate counter, subtract-based divider and result word register.
// ----------------------------------------------------------------------------
module fpe_datapath #(
    parameter int P_MAX_N = fpe_pkg::C_MAX_N
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [fpe_pkg::C_N_W-1:0]  i_n_value,
    input  fpe_pkg::t_dp_cmd           i_cmd,
    output fpe_pkg::t_dp_stat          o_stat,
    output logic                       o_valid,
    output logic [fpe_pkg::C_N_W-1:0]  o_prime_value,
    output logic [fpe_pkg::C_N_W-1:0]  o_exponent,
    output logic                       o_last_of_run
);
    import fpe_pkg::*;

    localparam logic [C_N_W-1:0] C_N_CAP =
        (P_MAX_N > C_N_SPAN - 1) ? C_N_W'(C_N_SPAN - 1) : C_N_W'(P_MAX_N);

    logic [C_N_W-1:0] clamped_n;
    logic [C_N_W-1:0] r_n;
    logic [C_N_W-1:0] r_v;
    logic [C_N_W-1:0] r_last;
    logic [C_N_W-1:0] r_r;
    logic [C_N_W-1:0] r_c;
    logic [C_N_W-1:0] r_sum;
    logic             r_out_valid;
    logic [C_N_W-1:0] r_out_prime;
    logic [C_N_W-1:0] r_out_exp;
    logic             r_out_last;

    assign clamped_n = (i_n_value > C_N_CAP) ? C_N_CAP : i_n_value;

    always_comb begin
        o_stat.v_gt_n    = (r_v > r_n);
        o_stat.v_prime   = C_PRIME_MASK[r_v];
        o_stat.r_ge_p    = (r_r >= r_v);
        o_stat.c_ge_p    = (r_c >= r_v);
        o_stat.p_is_last = (r_v == r_last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n    <= clamped_n;
            r_last <= C_LAST_PRIME[clamped_n];
            r_v    <= C_FIRST_PRIME;
        end else if (i_cmd.next || i_cmd.emit) begin
            r_v <= r_v + C_N_W'(1);
        end
        if (i_cmd.start_prime) begin
            r_r   <= r_n;
            r_c   <= '0;
            r_sum <= '0;
        end else if (i_cmd.sub) begin
            r_r   <= r_r - r_v;
            r_c   <= r_c + C_N_W'(1);
            r_sum <= r_sum + C_N_W'(1);
        end else if (i_cmd.restage) begin
            r_r <= r_c;
            r_c <= '0;
        end
        if (i_cmd.emit) begin
            r_out_prime <= r_v;
            r_out_exp   <= r_sum;
            r_out_last  <= (r_v == r_last);
        end
    end

    assign o_valid       = r_out_valid;
    assign o_prime_value = r_out_prime;
    assign o_exponent    = r_out_exp;
    assign o_last_of_run = r_out_last;

endmodule

// File: src/factorial_prime_exponents_unit.sv
// The scan steps through each candidate from 2 to the largest prime not above n, and per
// prime the divider subtracts once per unit of its exponent, restages once per further
// division stage and emits once; for n < 2 the scan stops at candidate 2 and emits no word.
// Throughput: one n at a time; busy stays high until the last word has gone out.
// Each word is on the outputs for one cycle with o_valid; the receiver cannot stall.
// Synchronous active-low reset returns to idle with no word pending.
// ----------------------------------------------------------------------------
// factorial_prime_exponents_unit
// Emits the prime factorization of n! as one word per prime, Legendre's formula.
// ----------------------------------------------------------------------------
`include "factorial_prime_exponents_unit_macros.svh"

module factorial_prime_exponents_unit #(
    parameter int P_MAX_N = fpe_pkg::C_MAX_N
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [fpe_pkg::C_N_W-1:0] i_n_value,
    output logic                      o_valid,
    output logic [fpe_pkg::C_N_W-1:0] o_prime_value,
    output logic [fpe_pkg::C_N_W-1:0] o_exponent,
    output logic                      o_last_of_run
);
    import fpe_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    fpe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    fpe_datapath #(
        .P_MAX_N (P_MAX_N)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_n_value     (i_n_value),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_valid       (o_valid),
        .o_prime_value (o_prime_value),
        .o_exponent    (o_exponent),
        .o_last_of_run (o_last_of_run)
    );

    `FPE_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not start")
    `FPE_ASSERT_IMPLIES(a_valid_from_work, o_valid, $past(busy), "word without work")
    `FPE_ASSERT_IMPLIES(a_last_ends_run, o_valid && o_last_of_run, !busy, "busy after last")
    `FPE_ASSERT_IMPLIES(a_word_range, o_valid, (o_prime_value >= C_FIRST_PRIME) && (o_exponent != '0), "bad word")

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks the factorial prime exponent unit. Numbers are sent over the start/
// busy handshake. Each accepted number is expanded into the expected prime and
// exponent words by an independent Legendre's formula calculation. Every
// strobed output word is compared with the oldest expected word. Directed
// small, boundary and saturating numbers come first, then random numbers
// with random start gaps.
// ----------------------------------------------------------------------------
module tb_top;
    import fpe_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 600;
    localparam int RANDOM_WORDS   = 154;
    localparam int STEADY_WORDS   = 30;
    localparam int EXP_CAP        = 2 ** C_N_W - 1;

    typedef struct {
        logic [C_N_W-1:0] prime;
        logic [C_N_W-1:0] power;
        logic             last;
    } t_factor;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic [C_N_W-1:0] i_n_value;
    logic             o_valid;
    logic [C_N_W-1:0] o_prime_value;
    logic [C_N_W-1:0] o_exponent;
    logic             o_last_of_run;

    t_factor pending_factors[$];
    int      error_count = 0;
    int      quiet_cycles = 0;

    factorial_prime_exponents_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_n_value     (i_n_value),
        .o_valid       (o_valid),
        .o_prime_value (o_prime_value),
        .o_exponent    (o_exponent),
        .o_last_of_run (o_last_of_run)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic void queue_factorization(input logic [C_N_W-1:0] n);
        int      top;
        int      v;
        int      d;
        int      q;
        int      power;
        int      found;
        bit      is_prime;
        t_factor f;
        top   = (int'(n) > C_MAX_N) ? C_MAX_N : int'(n);
        found = 0;
        for (v = 2; v <= top && found < C_MAX_RESULTS; v++) begin
            is_prime = 1'b1;
            for (d = 2; d * d <= v; d++) begin
                if (v % d == 0) begin
                    is_prime = 1'b0;
                end
            end
            if (is_prime) begin
                power = 0;
                q     = top;
                while (q >= v) begin
                    q     = q / v;
                    power = power + q;
                end
                if (power > EXP_CAP) begin
                    power = EXP_CAP;
                end
                f.prime = C_N_W'(v);
                f.power = C_N_W'(power);
                f.last  = 1'b0;
                pending_factors.insert(pending_factors.size(), f);
                found++;
            end
        end
        if (found > 0) begin
            pending_factors[pending_factors.size()-1].last = 1'b1;
        end
    endfunction

    function automatic void note_error(input string msg);
        error_count++;
        if (error_count <= 10) begin
            $display("%s", msg);
        end
    endfunction

    // check each strobed word against the oldest expected one
    always @(posedge i_clk) begin
        t_factor want;
        if (i_rst_n && o_valid) begin
            if (pending_factors.size() == 0) begin
                note_error($sformatf("unexpected word: prime %0d exponent %0d last %0b",
                    o_prime_value, o_exponent, o_last_of_run));
            end else begin
                want = pending_factors.pop_front();
                if (o_prime_value !== want.prime || o_exponent !== want.power ||
                    o_last_of_run !== want.last) begin
                    note_error($sformatf(
                        "mismatch: expected prime %0d exponent %0d last %0b, got %0d %0d %0b",
                        want.prime, want.power, want.last,
                        o_prime_value, o_exponent, o_last_of_run));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_word(input logic [C_N_W-1:0] n);
        @(negedge i_clk);
        start     = 1'b1;
        i_n_value = n;
        do begin
            @(posedge i_clk);
        end while (busy);
        queue_factorization(n);
    endtask

    task automatic hold_start(input int cycles);
        @(negedge i_clk);
        start = 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic test_small_numbers();
        send_word(C_N_W'(0));
        send_word(C_N_W'(1));
        send_word(C_N_W'(2));
        send_word(C_N_W'(3));
        hold_start(3);
        send_word(C_N_W'(1));
        send_word(C_N_W'(4));
        send_word(C_N_W'(5));
    endtask

    task automatic test_upper_range();
        send_word(C_N_W'(96));
        send_word(C_N_W'(97));
        send_word(C_N_W'(98));
        send_word(C_N_W'(99));
        send_word(C_N_W'(C_MAX_N));
    endtask

    task automatic test_saturation();
        send_word(C_N_W'(C_MAX_N + 1));
        send_word(C_N_W'(126));
        send_word(C_N_W'(127));
        send_word(C_N_W'(0));
    endtask

    task automatic test_random_numbers();
        int               i;
        int               pick;
        logic [C_N_W-1:0] n;
        for (i = 0; i < RANDOM_WORDS; i++) begin
            if (i < RANDOM_WORDS - STEADY_WORDS && $urandom_range(0, 3) == 0) begin
                hold_start($urandom_range(1, 8));
            end
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                n = C_N_W'($urandom_range(0, 1));
            end else if (pick == 1) begin
                n = C_N_W'($urandom_range(C_MAX_N + 1, 2 ** C_N_W - 1));
            end else begin
                n = C_N_W'($urandom_range(2, C_MAX_N));
            end
            send_word(n);
        end
    endtask

    initial begin
        i_rst_n   = 1'b0;
        start     = 1'b0;
        i_n_value = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_small_numbers();
        test_upper_range();
        test_saturation();
        test_random_numbers();

        @(negedge i_clk);
        start = 1'b0;
        while (pending_factors.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
